[rtl/core/batb_pkg.sv]
// shared types and constants for the affine box bounds block
package batb_pkg;

  localparam int CoordW   = 16;
  localparam int ProdW    = 2 * CoordW;
  localparam int AccW     = ProdW + 2;
  localparam int FracShift = 14;
  localparam int RndW     = AccW - FracShift;
  localparam int CfgW     = 48;
  localparam int CfgIdxW  = 2;
  localparam int Axes     = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_ROW0  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROW1  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROW2  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_TRANS = 2'd3;

  // reset values give the identity map
  localparam logic [CfgW-1:0] ROW0_RST  = 48'h0000_0000_4000;
  localparam logic [CfgW-1:0] ROW1_RST  = 48'h0000_4000_0000;
  localparam logic [CfgW-1:0] ROW2_RST  = 48'h4000_0000_0000;
  localparam logic [CfgW-1:0] TRANS_RST = 48'h0000_0000_0000;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
    logic                     last_box;
  } in_beat_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_min_x;
    logic signed [CoordW-1:0] out_min_y;
    logic signed [CoordW-1:0] out_min_z;
    logic signed [CoordW-1:0] out_max_x;
    logic signed [CoordW-1:0] out_max_y;
    logic signed [CoordW-1:0] out_max_z;
    logic                     last_out;
  } out_beat_t;

  // smaller and larger of the two products of one matrix term
  typedef struct packed {
    logic signed [ProdW-1:0] lo;
    logic signed [ProdW-1:0] hi;
  } term_t;

endpackage

[rtl/core/batb_term.sv]
// one matrix term: both corner products and their min and max
module batb_term (
  input  logic signed [batb_pkg::CoordW-1:0] lo,
  input  logic signed [batb_pkg::CoordW-1:0] hi,
  input  logic signed [batb_pkg::CoordW-1:0] coef,
  output batb_pkg::term_t                    term
);

  logic signed [batb_pkg::ProdW-1:0] p_lo;
  logic signed [batb_pkg::ProdW-1:0] p_hi;

  assign p_lo = lo * coef;
  assign p_hi = hi * coef;

  // the extreme of a sum over corners splits into per-term extremes
  always_comb begin
    if (p_lo < p_hi) begin
      term.lo = p_lo;
      term.hi = p_hi;
    end else begin
      term.lo = p_hi;
      term.hi = p_lo;
    end
  end

endmodule

[rtl/core/batb_reduce.sv]
// one output axis: sum terms and offset, round half up, saturate to q8.8
module batb_reduce (
  input  batb_pkg::term_t                    t0,
  input  batb_pkg::term_t                    t1,
  input  batb_pkg::term_t                    t2,
  input  logic signed [batb_pkg::CoordW-1:0] trans,
  output logic signed [batb_pkg::CoordW-1:0] out_lo,
  output logic signed [batb_pkg::CoordW-1:0] out_hi
);

  localparam int AccW = batb_pkg::AccW;
  localparam int RndW = batb_pkg::RndW;
  localparam logic signed [AccW-1:0] RoundBias = AccW'(1 << (batb_pkg::FracShift - 1));
  localparam logic signed [RndW-1:0] SatHi = RndW'(32767);
  localparam logic signed [RndW-1:0] SatLo = -RndW'(32768);

  function automatic logic signed [batb_pkg::CoordW-1:0] rnd_sat(
    input logic signed [AccW-1:0] a
  );
    logic signed [AccW-1:0] b;
    logic signed [RndW-1:0] r;
    b = a + RoundBias;
    r = b[AccW-1:batb_pkg::FracShift];
    if (r > SatHi) begin
      r = SatHi;
    end else if (r < SatLo) begin
      r = SatLo;
    end
    return r[batb_pkg::CoordW-1:0];
  endfunction

  logic signed [AccW-1:0] trans_w;
  logic signed [AccW-1:0] sum_lo;
  logic signed [AccW-1:0] sum_hi;

  assign trans_w = AccW'(trans) <<< batb_pkg::FracShift;
  assign sum_lo  = AccW'(t0.lo) + AccW'(t1.lo) + AccW'(t2.lo) + trans_w;
  assign sum_hi  = AccW'(t0.hi) + AccW'(t1.hi) + AccW'(t2.hi) + trans_w;

  // rounding is monotonic, so rounding the extreme sums gives the extremes
  assign out_lo = rnd_sat(sum_lo);
  assign out_hi = rnd_sat(sum_hi);

endmodule

[rtl/core/box_affine_transform_bounds_top.sv]
// top level of the affine box bounds block: registers, pipeline and control
//
//   port group  direction  beat contents
//   in_*        input      box min/max per axis (q8.8) and last_box
//   out_*       output     mapped box min/max per axis (q8.8, saturated), last_out
//   cfg_*       input      matrix rows (q2.14 x3) and translation (q8.8 x3)
//
// three-stage pipeline: input register, product register (18 multiplies,
// each term reduced to its min and max product), output register after the
// sum, round and saturate. one box per cycle unless a held result is stalled.
// a stalled valid output holds all stages; in_stall = out_stall && out_valid.
// synchronous active-low reset clears valids and restores the identity map.
module box_affine_transform_bounds_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  batb_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output batb_pkg::out_beat_t             out_data,
  input  logic                            cfg_we,
  input  logic [batb_pkg::CfgIdxW-1:0]    cfg_idx,
  input  logic [batb_pkg::CfgW-1:0]       cfg_data
);

  localparam int Axes   = batb_pkg::Axes;
  localparam int CoordW = batb_pkg::CoordW;

  // configuration registers
  logic [batb_pkg::CfgW-1:0] row_r [Axes];
  logic [batb_pkg::CfgW-1:0] trans_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= batb_pkg::ROW0_RST;
      row_r[1] <= batb_pkg::ROW1_RST;
      row_r[2] <= batb_pkg::ROW2_RST;
      trans_r  <= batb_pkg::TRANS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        batb_pkg::CFG_ROW0:  row_r[0] <= cfg_data;
        batb_pkg::CFG_ROW1:  row_r[1] <= cfg_data;
        batb_pkg::CFG_ROW2:  row_r[2] <= cfg_data;
        batb_pkg::CFG_TRANS: trans_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance: everything moves unless a held result is stalled
  logic out_valid_r;
  logic adv;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // stage 1: input register
  logic               s1_valid_r;
  batb_pkg::in_beat_t s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      s1_r <= in_data;
    end
  end

  // per-axis corner bounds of the registered box
  logic signed [CoordW-1:0] lo_v [Axes];
  logic signed [CoordW-1:0] hi_v [Axes];

  assign lo_v[0] = s1_r.min_x;
  assign lo_v[1] = s1_r.min_y;
  assign lo_v[2] = s1_r.min_z;
  assign hi_v[0] = s1_r.max_x;
  assign hi_v[1] = s1_r.max_y;
  assign hi_v[2] = s1_r.max_z;

  // stage 2: product extremes, term[i][j] for input axis i, output axis j
  batb_pkg::term_t term_w [Axes][Axes];
  batb_pkg::term_t term_r [Axes][Axes];
  logic            s2_valid_r;
  logic            s2_last_r;

  for (genvar i = 0; i < Axes; i++) begin : g_in_axis
    for (genvar j = 0; j < Axes; j++) begin : g_out_axis
      batb_term u_term (
        .lo   (lo_v[i]),
        .hi   (hi_v[i]),
        .coef (row_r[i][CoordW*j +: CoordW]),
        .term (term_w[i][j])
      );

      always_ff @(posedge clk) begin
        if (adv) begin
          term_r[i][j] <= term_w[i][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last_r <= s1_r.last_box;
    end
  end

  // stage 3: sum, round, saturate into the output register
  logic signed [CoordW-1:0] red_lo [Axes];
  logic signed [CoordW-1:0] red_hi [Axes];
  batb_pkg::out_beat_t      out_nxt;
  batb_pkg::out_beat_t      out_data_r;

  for (genvar j = 0; j < Axes; j++) begin : g_reduce
    batb_reduce u_reduce (
      .t0     (term_r[0][j]),
      .t1     (term_r[1][j]),
      .t2     (term_r[2][j]),
      .trans  (trans_r[CoordW*j +: CoordW]),
      .out_lo (red_lo[j]),
      .out_hi (red_hi[j])
    );
  end

  always_comb begin
    out_nxt.out_min_x = red_lo[0];
    out_nxt.out_min_y = red_lo[1];
    out_nxt.out_min_z = red_lo[2];
    out_nxt.out_max_x = red_hi[0];
    out_nxt.out_max_y = red_hi[1];
    out_nxt.out_max_z = red_hi[2];
    out_nxt.last_out  = s2_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // diagonal per-term extremes are ordered once registered
  a_term_order: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (term_r[0][0].lo <= term_r[0][0].hi) &&
                   (term_r[1][1].lo <= term_r[1][1].hi) &&
                   (term_r[2][2].lo <= term_r[2][2].hi))
    else $error("term min above term max");

  // mapped bounds are never inverted, even for an inverted input box
  a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.out_min_x <= out_data_r.out_max_x) &&
                    (out_data_r.out_min_y <= out_data_r.out_max_y) &&
                    (out_data_r.out_min_z <= out_data_r.out_max_z))
    else $error("output bounds inverted");

  // a held result is only released after it was taken
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result dropped");

  // a new input beat is never taken while the output is blocked
  a_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(s1_r) && $stable(out_data_r))
    else $error("pipeline moved under stall");
`endif

endmodule

[dv/box_affine_transform_bounds_top_tb.sv]
// self-checking testbench for the affine box bounds block, with directed rows and random boxes
module box_affine_transform_bounds_top_tb;

  localparam int CoordW    = batb_pkg::CoordW;
  localparam int CfgW      = batb_pkg::CfgW;
  localparam int CfgIdxW   = batb_pkg::CfgIdxW;
  localparam int Axes      = batb_pkg::Axes;
  localparam int FracShift = batb_pkg::FracShift;

  // three pipeline stages, plus a little margin before touching registers
  localparam int LATENCY = 3;
  localparam int SETTLE = LATENCY + 5;
  // cycles with no beat moving on either side before the run is abandoned
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int BOXES_PER_PHASE = 160;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  batb_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  batb_pkg::out_beat_t out_data;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0] cfg_data;

  box_affine_transform_bounds_top dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // our own copy of the four registers, indexed by register index
  logic [CfgW-1:0] cfg_copy [4];

  // bounds still owed by the block, oldest first
  batb_pkg::out_beat_t expected_boxes [$];
  batb_pkg::out_beat_t oldest_box;

  int errors = 0;
  int boxes_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  // idling controls: calm turns all idling off for the tail of the run
  bit calm = 1'b0;
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;

  string lane_names [6] = '{"out_min_x", "out_min_y", "out_min_z",
                            "out_max_x", "out_max_y", "out_max_z"};

  // one row of the directed table; want is only used when typed is set
  typedef struct {
    batb_pkg::in_beat_t box;
    bit typed;
    batb_pkg::out_beat_t want;
  } drill_row_t;
  drill_row_t drill_rows [$];

  // ---------------------------------------------------------------------------
  // bounds predictor
  // ---------------------------------------------------------------------------

  // signed 16-bit lane k of a packed register
  function automatic longint lane_of(input logic [CfgW-1:0] r, input int k);
    logic signed [CoordW-1:0] v;
    v = r[CoordW*k +: CoordW];
    return longint'(v);
  endfunction

  function automatic logic signed [CoordW-1:0] sat_q88(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[CoordW-1:0];
  endfunction

  // map all eight corners, round each to q8.8 half up, then take per-axis
  // min and max; saturation comes last, after the extremes are picked
  function automatic batb_pkg::out_beat_t bound_mapped_box(input batb_pkg::in_beat_t b);
    longint lo [3];
    longint hi [3];
    longint lowest [3];
    longint highest [3];
    longint acc;
    longint p;
    batb_pkg::out_beat_t o;
    lo[0] = b.min_x;
    lo[1] = b.min_y;
    lo[2] = b.min_z;
    hi[0] = b.max_x;
    hi[1] = b.max_y;
    hi[2] = b.max_z;
    for (int c = 0; c < 8; c++) begin
      for (int j = 0; j < Axes; j++) begin
        acc = lane_of(cfg_copy[batb_pkg::CFG_TRANS], j) <<< FracShift;
        // row i of the matrix scales input axis i (row vector convention)
        for (int i = 0; i < Axes; i++) begin
          acc += (c[i] ? hi[i] : lo[i]) * lane_of(cfg_copy[i], j);
        end
        // arithmetic shift floors, so this is round half toward +inf
        p = (acc + (longint'(1) <<< (FracShift - 1))) >>> FracShift;
        if (c == 0 || p < lowest[j]) lowest[j] = p;
        if (c == 0 || p > highest[j]) highest[j] = p;
      end
    end
    o.out_min_x = sat_q88(lowest[0]);
    o.out_min_y = sat_q88(lowest[1]);
    o.out_min_z = sat_q88(lowest[2]);
    o.out_max_x = sat_q88(highest[0]);
    o.out_max_y = sat_q88(highest[1]);
    o.out_max_z = sat_q88(highest[2]);
    o.last_out = b.last_box;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic batb_pkg::in_beat_t mk_box(
    input logic signed [CoordW-1:0] nx, ny, nz, xx, xy, xz,
    input logic last
  );
    return {nx, ny, nz, xx, xy, xz, last};
  endfunction

  // coordinate biased toward the edges of the q8.8 range
  function automatic logic signed [CoordW-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return CoordW'($urandom);
    endcase
  endfunction

  // mostly ordered boxes, some with free random fields (inverted axes
  // included), some built from edge values
  function automatic batb_pkg::in_beat_t gen_box();
    logic signed [CoordW-1:0] a [3];
    logic signed [CoordW-1:0] b [3];
    logic signed [CoordW-1:0] t;
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < Axes; k++) begin
      if (mode >= 8) begin
        a[k] = pick_coord();
        b[k] = pick_coord();
      end else begin
        a[k] = CoordW'($urandom);
        b[k] = CoordW'($urandom);
      end
      if (mode <= 5 && a[k] > b[k]) begin
        t = a[k];
        a[k] = b[k];
        b[k] = t;
      end
    end
    return mk_box(a[0], a[1], a[2], b[0], b[1], b[2], 1'($urandom));
  endfunction

  function automatic logic [CoordW-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'h4000;
      4: return 16'hc000;
      5: return 16'h0001;
      6: return 16'hffff;
      default: return CoordW'($urandom);
    endcase
  endfunction

  function automatic logic [CfgW-1:0] lanes3(input logic [CoordW-1:0] l0, l1, l2);
    return {l2, l1, l0};
  endfunction

  function automatic logic [CfgW-1:0] rand48();
    return CfgW'({$urandom, $urandom});
  endfunction

  task automatic add_row(input batb_pkg::in_beat_t box, input bit typed,
                         input batb_pkg::out_beat_t want);
    drill_row_t r;
    r.box = box;
    r.typed = typed;
    r.want = want;
    drill_rows.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_box(input batb_pkg::out_beat_t got, input batb_pkg::out_beat_t want);
    logic signed [CoordW-1:0] g;
    logic signed [CoordW-1:0] w;
    for (int k = 0; k < 2 * Axes; k++) begin
      g = got[$bits(batb_pkg::out_beat_t)-1-CoordW*k -: CoordW];
      w = want[$bits(batb_pkg::out_beat_t)-1-CoordW*k -: CoordW];
      if (g !== w) begin
        report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                  results_seen, lane_names[k], g, w));
      end
    end
    if (got.last_out !== want.last_out) begin
      report_mismatch($sformatf("result %0d last_out: got %b, expected %b",
                                results_seen, got.last_out, want.last_out));
    end
  endtask

  // one input beat: optional gap first, then hold valid and payload until taken.
  // the expectation is queued at the edge that accepts the beat
  task automatic send_box(input batb_pkg::in_beat_t b, input bit typed,
                          input batb_pkg::out_beat_t typed_want);
    if (gaps_on && !calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_boxes.push_back(typed ? typed_want : bound_mapped_box(b));
    boxes_sent++;
  endtask

  // stop sending and let every owed result come out, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all four registers back to back; only called with the pipe empty
  task automatic program_regs(input logic [CfgW-1:0] r0, r1, r2, tr);
    logic [CfgW-1:0] vals [4];
    vals[batb_pkg::CFG_ROW0] = r0;
    vals[batb_pkg::CFG_ROW1] = r1;
    vals[batb_pkg::CFG_ROW2] = r2;
    vals[batb_pkg::CFG_TRANS] = tr;
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= CfgIdxW'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      cfg_copy[i] = vals[i];
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, and the checker
  // ---------------------------------------------------------------------------

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm || !stall_on) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // every accepted result is compared with the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_boxes.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected: %h",
                                  results_seen, out_data));
      end else begin
        oldest_box = expected_boxes.pop_front();
        check_box(out_data, oldest_box);
      end
    end
  end

  // watchdog: counts cycles in which no beat moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results still owed",
               quiet_cycles, expected_boxes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    // after reset the registers hold the identity map
    cfg_copy[batb_pkg::CFG_ROW0] = batb_pkg::ROW0_RST;
    cfg_copy[batb_pkg::CFG_ROW1] = batb_pkg::ROW1_RST;
    cfg_copy[batb_pkg::CFG_ROW2] = batb_pkg::ROW2_RST;
    cfg_copy[batb_pkg::CFG_TRANS] = batb_pkg::TRANS_RST;

    // directed rows; under the identity map the bounds read straight off the box
    add_row(mk_box(0, 0, 0, 0, 0, 0, 0), 1'b1,
            batb_pkg::out_beat_t'(mk_box(0, 0, 0, 0, 0, 0, 0)));
    add_row(mk_box(0, 0, 0, 256, 256, 256, 0), 1'b1,
            batb_pkg::out_beat_t'(mk_box(0, 0, 0, 256, 256, 256, 0)));
    // full range box
    add_row(mk_box(-32768, -32768, -32768, 32767, 32767, 32767, 1), 1'b1,
            batb_pkg::out_beat_t'(mk_box(-32768, -32768, -32768, 32767, 32767, 32767, 1)));
    // degenerate boxes pinned at either end of the range
    add_row(mk_box(-32768, -32768, -32768, -32768, -32768, -32768, 0), 1'b1,
            batb_pkg::out_beat_t'(mk_box(-32768, -32768, -32768,
                                         -32768, -32768, -32768, 0)));
    add_row(mk_box(32767, 32767, 32767, 32767, 32767, 32767, 1), 1'b1,
            batb_pkg::out_beat_t'(mk_box(32767, 32767, 32767, 32767, 32767, 32767, 1)));
    // inverted boxes: corners are bounded as given, so min and max swap; then one ordered box
    add_row(mk_box(256, 256, 256, -256, -256, -256, 0), 1'b1,
            batb_pkg::out_beat_t'(mk_box(-256, -256, -256, 256, 256, 256, 0)));
    add_row(mk_box(32767, 32767, 32767, -32768, -32768, -32768, 1), 1'b1,
            batb_pkg::out_beat_t'(mk_box(-32768, -32768, -32768, 32767, 32767, 32767, 1)));
    add_row(mk_box(-1, -32768, 5, 1, 32767, 5, 0), 1'b1,
            batb_pkg::out_beat_t'(mk_box(-1, -32768, 5, 1, 32767, 5, 0)));
    // alternating bit patterns
    add_row(mk_box(16'shaaaa, 16'shaaaa, 16'shaaaa, 16'sh5555, 16'sh5555, 16'sh5555, 1), 1'b1,
            batb_pkg::out_beat_t'(mk_box(16'shaaaa, 16'shaaaa, 16'shaaaa,
                                         16'sh5555, 16'sh5555, 16'sh5555, 1)));
    add_row(gen_box(), 1'b0, '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table under the reset map
    foreach (drill_rows[r]) send_box(drill_rows[r].box, drill_rows[r].typed, drill_rows[r].want);
    wait_drained();

    // same table with every coefficient and offset at its top value, so most
    // corners overflow and saturate; checked against the predictor
    program_regs({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}});
    foreach (drill_rows[r]) send_box(drill_rows[r].box, 1'b0, '0);
    wait_drained();

    // random phases, each with its own register setting; the last one
    // restores the identity map and runs with no idling at all
    for (int p = 0; p < PHASES; p++) begin
      calm = (p == PHASES - 1);
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      case (p)
        0: program_regs({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        1: program_regs('0, '0, '0, rand48());
        2: program_regs(lanes3(pick_coef(), pick_coef(), pick_coef()),
                        lanes3(pick_coef(), pick_coef(), pick_coef()),
                        lanes3(pick_coef(), pick_coef(), pick_coef()),
                        lanes3(pick_coef(), pick_coef(), pick_coef()));
        3: program_regs(batb_pkg::ROW0_RST, batb_pkg::ROW1_RST, batb_pkg::ROW2_RST, rand48());
        // coefficients within plus or minus one, like a rotation and scale
        6: program_regs(lanes3(CoordW'($urandom_range(0, 32768) + 16'hc000),
                               CoordW'($urandom_range(0, 32768) + 16'hc000),
                               CoordW'($urandom_range(0, 32768) + 16'hc000)),
                        lanes3(CoordW'($urandom_range(0, 32768) + 16'hc000),
                               CoordW'($urandom_range(0, 32768) + 16'hc000),
                               CoordW'($urandom_range(0, 32768) + 16'hc000)),
                        lanes3(CoordW'($urandom_range(0, 32768) + 16'hc000),
                               CoordW'($urandom_range(0, 32768) + 16'hc000),
                               CoordW'($urandom_range(0, 32768) + 16'hc000)),
                        rand48());
        PHASES - 1: program_regs(batb_pkg::ROW0_RST, batb_pkg::ROW1_RST, batb_pkg::ROW2_RST,
                                 batb_pkg::TRANS_RST);
        default: program_regs(rand48(), rand48(), rand48(), rand48());
      endcase
      for (int n = 0; n < BOXES_PER_PHASE; n++) send_box(gen_box(), 1'b0, '0);
      // sender holds off here until every owed result is back
      wait_drained();
    end

    $display("ran %0d boxes through %0d register settings, %0d results checked",
             boxes_sent, settings_used + 1, results_seen);
    $display("directed edge and inverted boxes, saturating and random maps, random stalls");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
